>>> hw/rtl/ldpb_pkg.sv
// Shared types and constants for the luminance difference pixel blend core.
// Used by ldpb_ctrl, ldpb_dp and the top level; depends on nothing.
package ldpb_pkg;

	localparam int MAX_PIXELS_LOG2_DEF = 24;
	localparam int FRAC_BITS_DEF       = 12;

	// Rec.709 luma weights, Q0.16, summing to 65536
	localparam logic [16:0] LUM_WR = 17'd13933;
	localparam logic [16:0] LUM_WG = 17'd46871;
	localparam logic [16:0] LUM_WB = 17'd4732;

	localparam logic [12:0] BLEND_ONE = 13'd4096;

	localparam logic [1:0] LAST_CH = 2'd2;

	typedef enum logic [1:0] {
		ACT_ACCUM = 2'd0,
		ACT_FINAL = 2'd1,
		ACT_BLEND = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CFG_BLEND_AMOUNT = 2'd0,
		CFG_USE_AVERAGE  = 2'd1,
		CFG_CLAMP_ENABLE = 2'd2
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LMUL,
		ST_LSUM,
		ST_DIFF,
		ST_DMUL,
		ST_RND,
		ST_MMUL,
		ST_WRITE,
		ST_DIV_START,
		ST_DIV_WAIT
	} state_t;

	typedef struct packed {
		logic       latch;
		logic       acc;
		logic       lmul;
		logic       lsum;
		logic       diff;
		logic       dmul;
		logic       rnd;
		logic       mmul;
		logic       write_out;
		logic       div_start;
		logic       div_store;
		logic       clear_sums;
		logic [1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

>>> hw/rtl/ldpb_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Used by ldpb_dp for the average color; no package dependency.
module ldpb_div #(
	parameter int NW = 41,
	parameter int DW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   acc_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [DW:0]     r2;
	logic [DW+1:0]   trial;
	logic            ge;

	assign r2    = {rem_q, acc_q[NW-1]};
	assign trial = {1'b0, r2} - {2'b00, den};
	assign ge    = ~trial[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNTW'(1));
			if (start)
				cnt_q <= CNTW'(NW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial[DW-1:0] : r2[DW-1:0];
			acc_q <= {acc_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule

>>> hw/rtl/ldpb_dp.sv
// Datapath: accumulators, average store, blend arithmetic, output register.
// Depends on ldpb_pkg and ldpb_div; steered by cmd from ldpb_ctrl.
module ldpb_dp #(
	parameter int MAX_PIXELS_LOG2 = ldpb_pkg::MAX_PIXELS_LOG2_DEF,
	parameter int FRAC_BITS       = ldpb_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ldpb_pkg::cmd_t     cmd,
	output ldpb_pkg::sts_t     sts,
	input  logic               present,
	input  logic signed [15:0] src_r,
	input  logic signed [15:0] src_g,
	input  logic signed [15:0] src_b,
	input  logic signed [15:0] src_a,
	input  logic signed [15:0] top_r,
	input  logic signed [15:0] top_g,
	input  logic signed [15:0] top_b,
	input  logic signed [15:0] top_a,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	output logic signed [15:0] out_r,
	output logic signed [15:0] out_g,
	output logic signed [15:0] out_b,
	output logic signed [15:0] out_a
);

	localparam int SW  = MAX_PIXELS_LOG2 + 16;  // running sum
	localparam int CW  = MAX_PIXELS_LOG2 + 1;   // pixel count
	localparam int NW  = SW + 1;                // rounded dividend
	localparam int PW  = 34 - FRAC_BITS;        // rounded difference product
	localparam int PBW = PW + 14;               // product with blend amount
	localparam int MW  = PBW - 9;               // mixed channel before limiting

	localparam logic signed [33:0]   RND_P  = 34'(2 ** (FRAC_BITS - 1));
	localparam logic signed [PBW:0]  RND_M  = (PBW + 1)'(2048);
	localparam logic signed [MW-1:0] ONE_M  = MW'(2 ** FRAC_BITS);
	localparam logic signed [MW-1:0] SAT_HI = MW'(32767);
	localparam logic signed [MW-1:0] SAT_LO = MW'(-32768);

	// configuration
	logic [12:0] blend_amount_q;
	logic        use_average_q;
	logic        clamp_enable_q;

	// accumulation state
	logic signed [SW-1:0] sum_q [3];
	logic [CW-1:0]        cnt_q;
	logic signed [15:0]   avg_q [3];
	logic                 neg_q;

	// captured item
	logic               present_q;
	logic signed [15:0] src_q [4];
	logic signed [15:0] top_q [4];

	// blend step registers
	logic signed [33:0]    lp_q [3];
	logic signed [15:0]    lum_q;
	logic signed [16:0]    diff_q [3];
	logic signed [32:0]    dprod_q [3];
	logic signed [PW-1:0]  p_q [3];
	logic signed [PBW-1:0] pb_q [3];

	logic signed [15:0] out_q [4];

	// combinational
	logic signed [15:0]    top_in [3];
	logic signed [35:0]    lsum;
	logic signed [15:0]    ref_v [3];
	logic signed [33:0]    rsum [3];
	logic [12:0]           bclip;
	logic signed [PBW:0]   msum [3];
	logic signed [MW-1:0]  mval [3];
	logic signed [15:0]    res [3];
	logic signed [SW-1:0]  sel_sum;
	logic [SW-1:0]         mag;
	logic [NW-1:0]         num;
	logic                  div_done;
	logic [NW-1:0]         quot;
	logic signed [16:0]    q_signed;

	assign top_in[0] = top_r;
	assign top_in[1] = top_g;
	assign top_in[2] = top_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_amount_q <= ldpb_pkg::BLEND_ONE;
			use_average_q  <= 1'b1;
			clamp_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ldpb_pkg::CFG_BLEND_AMOUNT: blend_amount_q <= cfg_data;
				ldpb_pkg::CFG_USE_AVERAGE:  use_average_q  <= cfg_data[0];
				ldpb_pkg::CFG_CLAMP_ENABLE: clamp_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sums stop counting once the count reaches 2^MAX_PIXELS_LOG2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				avg_q[i] <= '0;
			end
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (cmd.acc && !cnt_q[CW-1]) begin
				for (int i = 0; i < 3; i++)
					sum_q[i] <= sum_q[i] + {{(SW-16){top_in[i][15]}}, top_in[i]};
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.div_start)
				neg_q <= sel_sum[SW-1];
			if (cmd.div_store)
				avg_q[cmd.ch] <= (cnt_q == '0) ? 16'sd0 : q_signed[15:0];
			if (cmd.clear_sums) begin
				for (int i = 0; i < 3; i++)
					sum_q[i] <= '0;
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		sel_sum  = sum_q[cmd.ch];
		mag      = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
		num      = NW'(mag) + NW'(cnt_q >> 1);
		q_signed = neg_q ? -$signed({1'b0, quot[15:0]}) : $signed({1'b0, quot[15:0]});
	end

	ldpb_div #(
		.NW(NW),
		.DW(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num),
		.den   (cnt_q),
		.done  (div_done),
		.quot  (quot)
	);

	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			present_q <= 1'b0;
		else if (cmd.latch)
			present_q <= present;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			src_q[0] <= src_r;
			src_q[1] <= src_g;
			src_q[2] <= src_b;
			src_q[3] <= src_a;
			top_q[0] <= top_r;
			top_q[1] <= top_g;
			top_q[2] <= top_b;
			top_q[3] <= top_a;
		end
	end

	always_comb begin
		lsum  = 36'(lp_q[0]) + 36'(lp_q[1]) + 36'(lp_q[2]) + 36'sd32768;
		bclip = (blend_amount_q > ldpb_pkg::BLEND_ONE) ? ldpb_pkg::BLEND_ONE : blend_amount_q;
		for (int i = 0; i < 3; i++) begin
			ref_v[i] = use_average_q ? avg_q[i] : top_q[i];
			rsum[i]  = 34'(dprod_q[i]) + RND_P;
			// v*b + src*(1-b) == src*1 + p*b, so only p*b is formed
			msum[i]  = (PBW + 1)'(pb_q[i]) + RND_M;
			mval[i]  = MW'(src_q[i]) + MW'($signed(msum[i][PBW:12]));
			if (clamp_enable_q) begin
				if (mval[i] < 0)
					mval[i] = '0;
				else if (mval[i] > ONE_M)
					mval[i] = ONE_M;
			end
			if (mval[i] > SAT_HI)
				res[i] = 16'sd32767;
			else if (mval[i] < SAT_LO)
				res[i] = -16'sd32768;
			else
				res[i] = mval[i][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lmul) begin
			lp_q[0] <= src_q[0] * $signed({1'b0, ldpb_pkg::LUM_WR});
			lp_q[1] <= src_q[1] * $signed({1'b0, ldpb_pkg::LUM_WG});
			lp_q[2] <= src_q[2] * $signed({1'b0, ldpb_pkg::LUM_WB});
		end
		if (cmd.lsum)
			lum_q <= lsum[31:16];
		for (int i = 0; i < 3; i++) begin
			if (cmd.diff)
				diff_q[i] <= {lum_q[15], lum_q} - {ref_v[i][15], ref_v[i]};
			if (cmd.dmul)
				dprod_q[i] <= top_q[3] * diff_q[i];
			if (cmd.rnd)
				p_q[i] <= rsum[i][33:FRAC_BITS];
			if (cmd.mmul)
				pb_q[i] <= p_q[i] * $signed({1'b0, bclip});
		end
		if (cmd.write_out) begin
			for (int i = 0; i < 3; i++)
				out_q[i] <= present_q ? res[i] : 16'sd0;
			out_q[3] <= present_q ? src_q[3] : 16'sd0;
		end
	end

	assign out_r = out_q[0];
	assign out_g = out_q[1];
	assign out_b = out_q[2];
	assign out_a = out_q[3];

endmodule

>>> hw/rtl/ldpb_ctrl.sv
// Controller: sequences blend steps and the three finalize divisions.
// Depends on ldpb_pkg; drives ldpb_dp through cmd_t, reads sts_t.
module ldpb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     action,
	input  logic           present,
	output logic           out_valid,
	input  logic           out_stall,
	output ldpb_pkg::cmd_t cmd,
	input  ldpb_pkg::sts_t sts
);

	ldpb_pkg::state_t state_q;
	ldpb_pkg::state_t state_nxt;
	logic [1:0]       ch_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ldpb_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (action)
						ldpb_pkg::ACT_BLEND:
							state_nxt = present ? ldpb_pkg::ST_LMUL : ldpb_pkg::ST_WRITE;
						ldpb_pkg::ACT_FINAL:
							state_nxt = ldpb_pkg::ST_DIV_START;
						default:
							state_nxt = ldpb_pkg::ST_IDLE;
					endcase
				end
			end
			ldpb_pkg::ST_LMUL:      state_nxt = ldpb_pkg::ST_LSUM;
			ldpb_pkg::ST_LSUM:      state_nxt = ldpb_pkg::ST_DIFF;
			ldpb_pkg::ST_DIFF:      state_nxt = ldpb_pkg::ST_DMUL;
			ldpb_pkg::ST_DMUL:      state_nxt = ldpb_pkg::ST_RND;
			ldpb_pkg::ST_RND:       state_nxt = ldpb_pkg::ST_MMUL;
			ldpb_pkg::ST_MMUL:      state_nxt = ldpb_pkg::ST_WRITE;
			ldpb_pkg::ST_WRITE: begin
				if (out_free)
					state_nxt = ldpb_pkg::ST_IDLE;
			end
			ldpb_pkg::ST_DIV_START: state_nxt = ldpb_pkg::ST_DIV_WAIT;
			ldpb_pkg::ST_DIV_WAIT: begin
				if (sts.div_done)
					state_nxt = (ch_q == ldpb_pkg::LAST_CH) ? ldpb_pkg::ST_IDLE
					                                        : ldpb_pkg::ST_DIV_START;
			end
			default:                state_nxt = ldpb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.ch   = ch_q;
		in_stall = (state_q != ldpb_pkg::ST_IDLE);
		case (state_q)
			ldpb_pkg::ST_IDLE: begin
				cmd.latch = in_valid;
				cmd.acc   = in_valid && present && (action == ldpb_pkg::ACT_ACCUM);
			end
			ldpb_pkg::ST_LMUL:      cmd.lmul = 1'b1;
			ldpb_pkg::ST_LSUM:      cmd.lsum = 1'b1;
			ldpb_pkg::ST_DIFF:      cmd.diff = 1'b1;
			ldpb_pkg::ST_DMUL:      cmd.dmul = 1'b1;
			ldpb_pkg::ST_RND:       cmd.rnd  = 1'b1;
			ldpb_pkg::ST_MMUL:      cmd.mmul = 1'b1;
			ldpb_pkg::ST_WRITE:     cmd.write_out = out_free;
			ldpb_pkg::ST_DIV_START: cmd.div_start = 1'b1;
			ldpb_pkg::ST_DIV_WAIT: begin
				cmd.div_store  = sts.div_done;
				cmd.clear_sums = sts.div_done && (ch_q == ldpb_pkg::LAST_CH);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ldpb_pkg::ST_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.latch)
				ch_q <= '0;
			else if (cmd.div_store && ch_q != ldpb_pkg::LAST_CH)
				ch_q <= ch_q + 2'd1;
			if (cmd.write_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/luminance_difference_pixel_blend_core.sv
// Luminance difference pixel blend core, one item at a time.
// Blend runs a chain of luma multiply, sum, difference, alpha multiply, round, mix multiply
// and write; the write waits while the output register still holds an unaccepted result.
// Blend with no pixel goes straight to the write. Finalize runs the shared one-bit-per-cycle
// divider once per channel.
// Reset (arst_n low, async) clears sums, count, average and config to defaults.
module luminance_difference_pixel_blend_core #(
	parameter int MAX_PIXELS_LOG2 = ldpb_pkg::MAX_PIXELS_LOG2_DEF,
	parameter int FRAC_BITS       = ldpb_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic               present,
	input  logic signed [15:0] src_r,
	input  logic signed [15:0] src_g,
	input  logic signed [15:0] src_b,
	input  logic signed [15:0] src_a,
	input  logic signed [15:0] top_r,
	input  logic signed [15:0] top_g,
	input  logic signed [15:0] top_b,
	input  logic signed [15:0] top_a,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_r,
	output logic signed [15:0] out_g,
	output logic signed [15:0] out_b,
	output logic signed [15:0] out_a,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data
);

	ldpb_pkg::cmd_t cmd;
	ldpb_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ldpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.present  (present),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	ldpb_dp #(
		.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2),
		.FRAC_BITS      (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.present  (present),
		.src_r    (src_r),
		.src_g    (src_g),
		.src_b    (src_b),
		.src_a    (src_a),
		.top_r    (top_r),
		.top_g    (top_g),
		.top_b    (top_b),
		.top_a    (top_a),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_r    (out_r),
		.out_g    (out_g),
		.out_b    (out_b),
		.out_a    (out_a)
	);

	// output register is only loaded when its previous item is gone
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> (!out_valid || !out_stall))
		else $error("output register overwritten while holding an item");

	// a finalize keeps the input side closed while the divider works
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action == ldpb_pkg::ACT_FINAL) |=> in_stall)
		else $error("input accepted right after a finalize");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (in_stall && !cmd.write_out))
		else $error("divider finished outside a finalize");

	// accumulate and finalize never produce a result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action != ldpb_pkg::ACT_BLEND) |=> !$rose(out_valid))
		else $error("result from a non-blend item");

endmodule
